// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the hash block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define ASSERT_CLKD(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_CLK(label, clk_s, prop, msg) \
    label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: hdl/mh2_pkg.sv
// ---------------------------------------------------------------------------
// mh2_pkg
// Types and constants shared by the MurmurHash2 stream block.
// ---------------------------------------------------------------------------
`default_nettype none

package mh2_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // What the back end has to do with a word
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PART,
        KIND_FULL
    } kind_t;

    typedef struct packed {
        logic [31:0] word;   // masked for partial words
        kind_t       kind;
        logic        first;
        logic [31:0] init;   // seed ^ key length
        logic        last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_HM,
        ST_PM,
        ST_FIN,
        ST_EMIT
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/mh2_front.sv
// ---------------------------------------------------------------------------
// mh2_front
// Accept input items, classify and mask the word, form the start value.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [31:0]   cfg_wdata,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   data_word,
    input  wire logic [2:0]    byte_count,
    input  wire logic          first_item,
    input  wire logic [30:0]   key_length,
    input  wire logic          last_item,
    output logic               push_valid,
    input  wire logic          push_ready,
    output mh2_pkg::item_t     push_item
);
    import mh2_pkg::*;

    logic [31:0] seed_reg;
    logic        stage_valid_reg;
    logic        stage_valid_next;
    item_t       stage_item_reg;
    item_t       item_next;
    logic        accept;

    assign in_ready   = !stage_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

    always_comb
    begin
        item_next.first = first_item;
        item_next.last  = last_item;
        item_next.init  = seed_reg ^ {1'b0, key_length};
        case (byte_count)
            3'd0:
            begin
                item_next.kind = KIND_NONE;
                item_next.word = '0;
            end
            3'd1:
            begin
                item_next.kind = KIND_PART;
                item_next.word = {24'd0, data_word[7:0]};
            end
            3'd2:
            begin
                item_next.kind = KIND_PART;
                item_next.word = {16'd0, data_word[15:0]};
            end
            3'd3:
            begin
                item_next.kind = KIND_PART;
                item_next.word = {8'd0, data_word[23:0]};
            end
            default:
            begin
                // saturate: four bytes and above are a full word
                item_next.kind = KIND_FULL;
                item_next.word = data_word;
            end
        endcase
    end

    assign stage_valid_next = accept || (stage_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mh2_fifo.sv
// ---------------------------------------------------------------------------
// mh2_fifo
// Short queue of classified items between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire mh2_pkg::item_t push_item,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output mh2_pkg::item_t     pop_item
);
    import mh2_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: hdl/mh2_back.sv
// ---------------------------------------------------------------------------
// mh2_back
// Hash engine: one shared constant multiplier stepped by a sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module mh2_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire mh2_pkg::item_t pop_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [31:0]         hash_value
);
    import mh2_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    logic [31:0] h_reg;          // running hash
    logic [31:0] h_next;
    logic [31:0] mul_reg;
    logic [31:0] mul_next;
    logic [31:0] mul_in;
    logic [31:0] k_reg;
    logic [31:0] k_next;
    logic        last_reg;
    logic        last_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_value_reg;
    logic [31:0] out_value_next;
    logic [31:0] h_start;
    logic        load_out;

    assign out_valid  = out_valid_reg;
    assign hash_value = out_value_reg;
    assign h_start    = pop_item.first ? pop_item.init : h_reg;
    assign mul_next   = mul_in * MIX_MUL;

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        mul_in     = h_reg;
        pop_ready  = 1'b0;
        load_out   = 1'b0;
        out_value_next = out_value_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    last_next = pop_item.last;
                    case (pop_item.kind)
                        KIND_FULL:
                        begin
                            h_next     = h_start;
                            mul_in     = pop_item.word;
                            state_next = ST_K1;
                        end
                        KIND_PART:
                        begin
                            mul_in     = h_start ^ pop_item.word;
                            state_next = ST_PM;
                        end
                        default:
                        begin
                            h_next     = h_start;
                            state_next = pop_item.last ? ST_FIN : ST_IDLE;
                        end
                    endcase
                end
            end
            ST_K1:
            begin
                mul_in     = mul_reg ^ (mul_reg >> MIX_SHIFT);
                state_next = ST_K2;
            end
            ST_K2:
            begin
                k_next     = mul_reg;
                mul_in     = h_reg;
                state_next = ST_HM;
            end
            ST_HM:
            begin
                h_next     = mul_reg ^ k_reg;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_PM:
            begin
                h_next     = mul_reg;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                mul_in     = h_reg ^ (h_reg >> FIN_SHIFT_A);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // keep the finaliser product steady while the slot is busy
                mul_in = h_reg ^ (h_reg >> FIN_SHIFT_A);
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_value_next = mul_reg ^ (mul_reg >> FIN_SHIFT_B);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg       <= mul_next;
        k_reg         <= k_next;
        out_value_reg <= out_value_next;
    end

endmodule

`default_nettype wire

// File: hdl/murmur2_hash_stream_top.sv
// ---------------------------------------------------------------------------
// murmur2_hash_stream_top
// Streaming 32-bit MurmurHash2 over little-endian key words.
// ---------------------------------------------------------------------------
// Feed a key as a run of 32-bit words, first byte in bits 7:0; mark the first
// word with first_item (key_length is read there and seeds the hash as
// hash_seed ^ key_length) and the final word with last_item, which yields one
// hash_value item. byte_count gives the valid bytes (above four counts as
// four); an empty key is a single item with both marks and no bytes. Write
// the seed through cfg_we/cfg_wdata only while the block is idle. The back
// end owns one 32x32 constant multiplier and steps it once a cycle: a full
// word passes K1, K2 and HM, a partial word PM, and a last item then FIN and
// EMIT for the finalizer; it takes no new item until back in IDLE. A front
// register and a short queue (QUEUE_DEPTH items) sit ahead of it, and an
// output register behind it, so input and output stall independently.
// ---------------------------------------------------------------------------
`default_nettype none

module murmur2_hash_stream_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        first_item,
    input  wire logic [30:0] key_length,
    input  wire logic        last_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);
    import mh2_pkg::*;

    // Front to queue
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    // Queue to back end
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // Classify, mask partial words and form the start value
    mh2_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .first_item (first_item),
        .key_length (key_length),
        .last_item  (last_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouple the front from the multi-cycle engine
    mh2_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Mix, fold, finalise and hold the result
    mh2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule

`default_nettype wire

// File: hdl/mh2_checker.sv
// ---------------------------------------------------------------------------
// mh2_checker
// Port-level checks on the hash block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mh2_checker #(
    parameter int QUEUE_DEPTH = 2
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        last_item,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] hash_value
);
    // Last items accepted whose hash has not yet been taken
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       in_last;
    logic       out_take;

    assign in_last  = in_valid && in_ready && last_item;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_last && !out_take)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_take && !in_last)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
    `ASSERT_CLKD(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(hash_value), "result changed while stalled")
    `ASSERT_CLKD(a_no_spurious, clk, rst_n, out_valid |-> pending_reg != 4'd0, "result without a last item")
    `ASSERT_CLK(a_capacity, clk, !rst_n || pending_reg <= 4'(QUEUE_DEPTH + 3), "more items held than storage allows")

endmodule

bind murmur2_hash_stream_top mh2_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mh2_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last_item  (last_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
);

`default_nettype wire

// File: test/murmur2_hash_stream_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// murmur2_hash_stream_top_test
// Self-checking bench for the streaming MurmurHash2 block. A local model of
// the running hash predicts every hash_value item as each key word is
// accepted. Named tests cover corner cases, seed settings, output back-pressure
// and a long randomised run. Both handshakes see random idle bursts.
// ---------------------------------------------------------------------------

module murmur2_hash_stream_top_test;

    import mh2_pkg::*;

    // Cycles to let pass once the last hash has come, so that words which
    // produce no result have left the queue and the multiplier.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 600;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_wdata  = '0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [31:0] data_word  = '0;
    logic [2:0]  byte_count = '0;
    logic        first_item = 1'b0;
    logic [30:0] key_length = '0;
    logic        last_item  = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [31:0] hash_value;

    // Local copy of the block's state and its seed register
    logic [31:0] hash_state = '0;
    logic [31:0] seed_copy  = '0;
    logic [31:0] hash_expect_q[$];

    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    bit          quiet          = 1'b0;   // no random idle bursts on either side
    int unsigned rx_hold_len    = 0;      // long receiver hold-off request

    murmur2_hash_stream_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .first_item (first_item),
        .key_length (key_length),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Hash model
    // -----------------------------------------------------------------------

    // Scramble one full key word before it is folded into the hash
    function automatic logic [31:0] mix_key(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_MUL;
        t = t ^ (t >> MIX_SHIFT);
        t = t * MIX_MUL;
        return t;
    endfunction

    // Final avalanche applied only when a key is closed
    function automatic logic [31:0] finalize_hash(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> FIN_SHIFT_A);
        t = t * MIX_MUL;
        t = t ^ (t >> FIN_SHIFT_B);
        return t;
    endfunction

    // Advance the running hash by one accepted word; queue the hash on a
    // last word
    task automatic fold_word(input logic [31:0] word, input logic [2:0] cnt,
                             input logic first, input logic [30:0] len,
                             input logic last);
        logic [31:0] h;
        logic [2:0]  n;
        logic [31:0] mask;
        h = first ? (seed_copy ^ {1'b0, len}) : hash_state;
        // counts above four saturate to a full word
        n = (cnt > 3'd4) ? 3'd4 : cnt;
        if (n == 3'd4)
            h = (h * MIX_MUL) ^ mix_key(word);
        else if (n != 3'd0)
        begin
            // drop the bytes above the count
            mask = (32'h1 << (8 * n)) - 32'h1;
            h    = (h ^ (word & mask)) * MIX_MUL;
        end
        // the pre-finalise value carries over into the next key
        hash_state = h;
        if (last)
            hash_expect_q.push_back(finalize_hash(h));
    endtask

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------

    // Offer one item and hold it until accepted. Valid is left high on return;
    // the caller either offers the next item in the same step or drops valid.
    task automatic send_word(input logic [31:0] word, input logic [2:0] cnt,
                             input logic first, input logic [30:0] len,
                             input logic last);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= word;
        byte_count <= cnt;
        first_item <= first;
        key_length <= len;
        last_item  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fold_word(word, cnt, first, len, last);
        items_sent++;
    endtask

    // Stream one key of nbytes bytes. A sloppy key may lose its start mark,
    // carry stray partial words mid-key, or use over-range byte counts.
    task automatic send_key(input int nbytes, input logic [30:0] len_field,
                            input bit sloppy);
        int          remain;
        logic [2:0]  cnt;
        logic        first;
        remain = nbytes;
        first  = 1'b1;
        if (sloppy && $urandom_range(0, 3) == 0)
            first = 1'b0;
        do
        begin
            if (sloppy && remain > 4 && $urandom_range(0, 4) == 0)
            begin
                send_word($urandom, 3'($urandom_range(0, 3)), first, len_field, 1'b0);
                first = 1'b0;
            end
            cnt = (remain >= 4) ? 3'd4 : remain[2:0];
            if (cnt == 3'd4 && sloppy && $urandom_range(0, 2) == 0)
                cnt = 3'($urandom_range(5, 7));
            remain = remain - ((remain >= 4) ? 4 : remain);
            send_word($urandom, cnt, first, len_field, remain == 0);
            first = 1'b0;
        end
        while (remain > 0);
    endtask

    // Drop valid, wait for every outstanding hash, then let the tail settle
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (hash_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Change the seed while the block is idle
    task automatic write_seed(input logic [31:0] value);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        seed_copy = value;
    endtask

    // -----------------------------------------------------------------------
    // Receiver side: random stall bursts, plus one long hold-off on request.
    // Each pass makes exactly one assignment to out_ready.
    // -----------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len != 0)
            begin
                out_ready <= 1'b0;
                // count the hold-off here, one edge at a time
                repeat (rx_hold_len - 1) @(posedge clk);
                rx_hold_len = 0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 16);
                out_ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Result checker: compare each accepted hash with the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (hash_expect_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("hash_value %08h arrived with nothing expected", hash_value);
                mismatch_count++;
            end
            else
            begin
                want = hash_expect_q.pop_front();
                if (hash_value !== want)
                begin
                    if (mismatch_count < 10)
                        $display("hash_value: expected %08h, got %08h", want, hash_value);
                    mismatch_count++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Corner cases with the seed at its reset value
    task automatic test_directed();
        // words before any start mark carry on from the reset hash
        send_word($urandom, 3'd4, 1'b0, 31'd0, 1'b0);
        send_word(32'hffff_ffff, 3'd3, 1'b0, 31'd0, 1'b1);
        // empty keys, smallest and largest length field
        send_word($urandom, 3'd0, 1'b1, 31'd0, 1'b1);
        send_word($urandom, 3'd0, 1'b1, 31'h7fff_ffff, 1'b1);
        // single full words at the data extremes
        send_word(32'h0000_0000, 3'd4, 1'b1, 31'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1, 31'd4, 1'b1);
        // partial words with junk in the unused bytes
        send_word(32'hffff_ffff, 3'd1, 1'b1, 31'd1, 1'b1);
        send_word(32'ha5c3_96e1, 3'd2, 1'b1, 31'd2, 1'b1);
        send_word(32'h8000_0001, 3'd3, 1'b1, 31'd3, 1'b1);
        // over-range counts behave as full words
        send_word($urandom, 3'd5, 1'b1, 31'd4, 1'b1);
        send_word($urandom, 3'd6, 1'b1, 31'd4, 1'b1);
        send_word($urandom, 3'd7, 1'b1, 31'd4, 1'b1);
        // partial word to open a key, then a no-byte word, then a closing word
        send_word($urandom, 3'd2, 1'b1, 31'd6, 1'b0);
        send_word($urandom, 3'd0, 1'b0, 31'd6, 1'b0);
        send_word($urandom, 3'd4, 1'b0, 31'd6, 1'b1);
        // length field that does not match the bytes streamed
        send_word($urandom, 3'd4, 1'b1, 31'd1000, 1'b1);
        // carry on after a closed key with no new start mark
        send_word($urandom, 3'd4, 1'b0, 31'h5555_5555, 1'b0);
        send_word($urandom, 3'd1, 1'b0, 31'h2aaa_aaaa, 1'b1);
    endtask

    // Seed extremes and a random seed, each with an empty and a short key
    task automatic test_seed_settings();
        write_seed(32'hffff_ffff);
        send_word($urandom, 3'd0, 1'b1, 31'd0, 1'b1);
        send_word($urandom, 3'd3, 1'b1, 31'd3, 1'b1);
        write_seed($urandom);
        send_word($urandom, 3'd0, 1'b1, 31'd0, 1'b1);
        send_word($urandom, 3'd3, 1'b1, 31'd3, 1'b1);
        write_seed(32'h0000_0000);
        send_word($urandom, 3'd0, 1'b1, 31'd0, 1'b1);
        send_word($urandom, 3'd3, 1'b1, 31'd3, 1'b1);
    endtask

    // Hold the receiver off while short keys keep coming, so the block fills
    // and stalls its input; then pause the sender until all hashes are in.
    task automatic test_backpressure();
        quiet       = 1'b1;
        rx_hold_len = 200;
        repeat (30)
            send_key($urandom_range(0, 4), 31'($urandom_range(0, 4)), 1'b0);
        wait_until_drained();
        quiet = 1'b0;
    endtask

    // Mostly well-formed keys with random content, some broken keys and some
    // pure noise; the seed changes between chunks and the last chunk runs
    // without idling.
    task automatic test_random();
        int unsigned goal;
        int unsigned chunk;
        int          nbytes;
        logic [30:0] len_field;
        for (chunk = 0; chunk < 3; chunk++)
        begin
            write_seed(chunk == 1 ? 32'hffff_ffff : $urandom);
            if (chunk == 2)
                quiet = 1'b1;
            goal = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                              31'($urandom), 1'($urandom_range(0, 1)));
                else
                begin
                    // mostly short keys, now and then a longer one
                    nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                         : $urandom_range(0, 16);
                    len_field = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'(nbytes);
                    send_key(nbytes, len_field, $urandom_range(0, 8) == 0);
                end
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Sequence: reset once, run the tests, then give the verdict
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_seed_settings();
        test_backpressure();
        test_random();
        wait_until_drained();
        if (mismatch_count == 0 && hash_expect_q.size() == 0)
            $display("murmur2_hash_stream_top: match");
        else
            $display("murmur2_hash_stream_top: mismatch");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #5_000_000;
        $display("murmur2_hash_stream_top: mismatch");
        $finish;
    end

endmodule

// File: murmur2_hash_stream_top.f
+incdir+hdl
hdl/mh2_pkg.sv
hdl/mh2_front.sv
hdl/mh2_fifo.sv
hdl/mh2_back.sv
hdl/murmur2_hash_stream_top.sv
hdl/mh2_checker.sv
test/murmur2_hash_stream_top_test.sv
